### rtl/upcp_pkg.sv
package upcp_pkg;

  // Command buffer capacity; a command holds at most CommandCapacity-1 bytes.
  localparam int unsigned CommandCapacity = 64;
  localparam int unsigned LenWidth = $clog2(CommandCapacity);

  localparam int unsigned KwCount = 18;
  localparam int unsigned KwMaxLen = 21;

  typedef logic [LenWidth-1:0] cmd_len_t;
  typedef logic [KwCount-1:0] kw_mask_t;

  localparam logic [7:0] PollMarker = 8'h99;
  localparam logic [7:0] SlotIdReset = 8'h03;
  localparam logic [7:0] CharRestart = 8'h3E;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharNul = 8'h00;

  localparam logic [2:0] EvNone = 3'd0;
  localparam logic [2:0] EvPollResponse = 3'd1;
  localparam logic [2:0] EvMatched = 3'd2;
  localparam logic [2:0] EvUnknown = 3'd3;
  localparam logic [2:0] EvOverflow = 3'd4;
  localparam logic [2:0] EvLineError = 3'd5;

  localparam logic [1:0] ViewStatus = 2'd0;
  localparam logic [1:0] ViewConfig = 2'd1;
  localparam logic [1:0] ViewDiag = 2'd2;

  localparam logic [2:0] ActNone = 3'd0;
  localparam logic [2:0] ActCaptureBaseline = 3'd1;
  localparam logic [2:0] ActClearBaseline = 3'd2;
  localparam logic [2:0] ActDefaultProfile = 3'd3;
  localparam logic [2:0] ActFastProfile = 3'd4;
  localparam logic [2:0] ActStableProfile = 3'd5;
  localparam logic [2:0] ActResetDiag = 3'd6;

  // Keyword text, right-justified: the first character sits in the highest used byte.
  localparam logic [KwMaxLen*8-1:0] KwText [KwCount] = '{
    "status",
    "packet:status",
    "config",
    "packet:config",
    "diagnostics",
    "packet:diagnostics",
    "baseline:capture",
    {"capture", "_baseline"},
    "baseline:clear",
    {"clear", "_baseline"},
    {"laser", "_profile:default"},
    "profile:default",
    {"laser", "_profile:fast"},
    "profile:fast",
    {"laser", "_profile:stable"},
    "profile:stable",
    "diagnostics:reset",
    {"reset", "_diagnostics"}
  };

  localparam cmd_len_t KwLen [KwCount] = '{
    cmd_len_t'(6), cmd_len_t'(13), cmd_len_t'(6), cmd_len_t'(13),
    cmd_len_t'(11), cmd_len_t'(18), cmd_len_t'(16), cmd_len_t'(16),
    cmd_len_t'(14), cmd_len_t'(14), cmd_len_t'(21), cmd_len_t'(15),
    cmd_len_t'(18), cmd_len_t'(12), cmd_len_t'(20), cmd_len_t'(14),
    cmd_len_t'(17), cmd_len_t'(17)
  };

  localparam logic [1:0] KwView [KwCount] = '{
    ViewStatus, ViewStatus, ViewConfig, ViewConfig, ViewDiag, ViewDiag,
    ViewConfig, ViewConfig, ViewConfig, ViewConfig, ViewConfig, ViewConfig,
    ViewConfig, ViewConfig, ViewConfig, ViewConfig, ViewDiag, ViewDiag
  };

  localparam logic [2:0] KwAction [KwCount] = '{
    ActNone, ActNone, ActNone, ActNone, ActNone, ActNone,
    ActCaptureBaseline, ActCaptureBaseline, ActClearBaseline, ActClearBaseline,
    ActDefaultProfile, ActDefaultProfile, ActFastProfile, ActFastProfile,
    ActStableProfile, ActStableProfile, ActResetDiag, ActResetDiag
  };

  // Character of keyword k at position pos, or zero past its end.
  function automatic logic [7:0] kw_char(int unsigned k, cmd_len_t pos);
    logic [7:0] ch;
    ch = CharNul;
    if (pos < KwLen[k]) begin
      ch = KwText[k][(int'(KwLen[k]) - 1 - int'(pos)) * 8 +: 8];
    end
    return ch;
  endfunction

endpackage

### rtl/upcp_if.sv
interface upcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink (input valid, input rx_byte, input line_error, output ready);
endinterface

interface upcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  view_select;
  logic [2:0]  sensor_action;
  logic [31:0] receive_count;
  logic [31:0] fault_count;

  modport source (
    output valid, output event_kind, output view_select, output sensor_action,
    output receive_count, output fault_count, input ready
  );
  modport sink (
    input valid, input event_kind, input view_select, input sensor_action,
    input receive_count, input fault_count, output ready
  );
endinterface

### rtl/uart_poll_and_command_parser_top.sv
// Serial poll responder and command parser. Each input item is one received byte or one
// line-error event, and each produces exactly one result item. Items are accepted one per
// cycle: the whole parse step, including the parallel compare of the byte against all 18
// keywords, completes in the cycle of acceptance and lands in a single output register, so
// the result appears in the cycle after acceptance and the input stalls only while that
// register holds an item the sink has not taken. The slot id register may be written only
// while no item is in flight.
module uart_poll_and_command_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  upcp_in_if.sink             in_i,
  upcp_out_if.source          out_o
);

  logic [7:0]              slot_id_q;
  logic                    awaiting_slot_q, awaiting_slot_d;
  upcp_pkg::cmd_len_t      cmd_len_q, cmd_len_d;
  upcp_pkg::kw_mask_t      cand_q, cand_d;
  logic                    text_ended_q, text_ended_d;
  logic [1:0]              view_q, view_d;
  logic [31:0]             recv_q, recv_d;
  logic [31:0]             fault_q, fault_d;

  logic                    out_valid_q;
  logic [2:0]              ev_q, ev_d;
  logic [2:0]              act_q, act_d;

  logic                    accept;
  upcp_pkg::kw_mask_t      len_mask;
  upcp_pkg::kw_mask_t      char_mask;
  upcp_pkg::kw_mask_t      final_mask;
  logic                    hit;
  logic [1:0]              hit_view;
  logic [2:0]              hit_act;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    for (int unsigned k = 0; k < upcp_pkg::KwCount; k++) begin
      len_mask[k]  = (upcp_pkg::KwLen[k] == cmd_len_q);
      char_mask[k] = (upcp_pkg::kw_char(k, cmd_len_q) == in_i.rx_byte);
    end
  end

  assign final_mask = text_ended_q ? cand_q : (cand_q & len_mask);

  // The lowest-numbered surviving keyword wins.
  always_comb begin
    hit = 1'b0;
    hit_view = upcp_pkg::ViewStatus;
    hit_act = upcp_pkg::ActNone;
    for (int k = int'(upcp_pkg::KwCount) - 1; k >= 0; k--) begin
      if (final_mask[k]) begin
        hit = 1'b1;
        hit_view = upcp_pkg::KwView[k];
        hit_act = upcp_pkg::KwAction[k];
      end
    end
  end

  always_comb begin
    awaiting_slot_d = awaiting_slot_q;
    cmd_len_d = cmd_len_q;
    cand_d = cand_q;
    text_ended_d = text_ended_q;
    view_d = view_q;
    recv_d = recv_q;
    fault_d = fault_q;
    ev_d = upcp_pkg::EvNone;
    act_d = upcp_pkg::ActNone;

    priority if (in_i.line_error) begin
      fault_d = fault_q + 32'd1;
      ev_d = upcp_pkg::EvLineError;
    end else if (awaiting_slot_q) begin
      awaiting_slot_d = 1'b0;
      if (in_i.rx_byte == slot_id_q) begin
        recv_d = recv_q + 32'd1;
        ev_d = upcp_pkg::EvPollResponse;
      end
    end else if (in_i.rx_byte == upcp_pkg::PollMarker) begin
      awaiting_slot_d = 1'b1;
    end else if (in_i.rx_byte == upcp_pkg::CharRestart) begin
      cmd_len_d = '0;
      cand_d = '1;
      text_ended_d = 1'b0;
    end else if (in_i.rx_byte == upcp_pkg::CharCr) begin
      ev_d = upcp_pkg::EvNone;
    end else if (in_i.rx_byte == upcp_pkg::CharLf) begin
      if (cmd_len_q != '0) begin
        recv_d = recv_q + 32'd1;
        cmd_len_d = '0;
        cand_d = '1;
        text_ended_d = 1'b0;
        if (hit) begin
          ev_d = upcp_pkg::EvMatched;
          act_d = hit_act;
          view_d = hit_view;
          if (hit_act == upcp_pkg::ActResetDiag) begin
            recv_d = '0;
            fault_d = '0;
          end
        end else begin
          ev_d = upcp_pkg::EvUnknown;
          fault_d = fault_q + 32'd1;
        end
      end
    end else if (cmd_len_q < upcp_pkg::cmd_len_t'(upcp_pkg::CommandCapacity - 1)) begin
      if (!text_ended_q) begin
        if (in_i.rx_byte == upcp_pkg::CharNul) begin
          cand_d = cand_q & len_mask;
          text_ended_d = 1'b1;
        end else begin
          cand_d = cand_q & char_mask;
        end
      end
      cmd_len_d = upcp_pkg::cmd_len_t'(cmd_len_q + 1'b1);
    end else begin
      cmd_len_d = '0;
      cand_d = '1;
      text_ended_d = 1'b0;
      fault_d = fault_q + 32'd1;
      ev_d = upcp_pkg::EvOverflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_id_q <= upcp_pkg::SlotIdReset;
    end else if (cfg_we_i) begin
      slot_id_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_slot_q <= 1'b0;
      cmd_len_q <= '0;
      cand_q <= '1;
      text_ended_q <= 1'b0;
      view_q <= upcp_pkg::ViewStatus;
      recv_q <= '0;
      fault_q <= '0;
    end else if (accept) begin
      awaiting_slot_q <= awaiting_slot_d;
      cmd_len_q <= cmd_len_d;
      cand_q <= cand_d;
      text_ended_q <= text_ended_d;
      view_q <= view_d;
      recv_q <= recv_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q <= ev_d;
      act_q <= act_d;
    end
  end

  // Counts and view live in the state registers, which change only on acceptance.
  assign out_o.valid = out_valid_q;
  assign out_o.event_kind = ev_q;
  assign out_o.sensor_action = act_q;
  assign out_o.view_select = view_q;
  assign out_o.receive_count = recv_q;
  assign out_o.fault_count = fault_q;

  a_action_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (act_q != upcp_pkg::ActNone) |-> ev_q == upcp_pkg::EvMatched)
    else $error("sensor action reported without a matched command");

  a_reset_diag_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (act_q == upcp_pkg::ActResetDiag) |-> (recv_q == '0) && (fault_q == '0))
    else $error("reset diagnostics did not clear the counts");

  a_text_end_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_ended_q |-> cmd_len_q != '0)
    else $error("text end flagged on an empty command");

  a_line_error_keeps_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.line_error |=> $stable(cmd_len_q) && $stable(cand_q)
      && $stable(awaiting_slot_q))
    else $error("line error disturbed the parser state");

endmodule

### test/tb_uart_poll_and_command_parser_top.sv
`timescale 1ns / 1ps

module tb_uart_poll_and_command_parser_top;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  view_select;
    logic [2:0]  sensor_action;
    logic [31:0] receive_count;
    logic [31:0] fault_count;
  } parse_result_t;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 4;
  localparam int RandomItems = 1290;
  localparam int MaxReported = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_data;

  upcp_in_if in_if ();
  upcp_out_if out_if ();

  uart_poll_and_command_parser_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk = ~clk;

  string kw_text [upcp_pkg::KwCount] = '{
    "status", "packet:status", "config", "packet:config", "diagnostics",
    "packet:diagnostics", "baseline:capture", {"capture", "_baseline"}, "baseline:clear",
    {"clear", "_baseline"}, {"laser", "_profile:default"}, "profile:default",
    {"laser", "_profile:fast"}, "profile:fast", {"laser", "_profile:stable"},
    "profile:stable", "diagnostics:reset", {"reset", "_diagnostics"}
  };
  logic [1:0] kw_view [upcp_pkg::KwCount] = '{
    upcp_pkg::ViewStatus, upcp_pkg::ViewStatus, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig,
    upcp_pkg::ViewDiag, upcp_pkg::ViewDiag, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig,
    upcp_pkg::ViewConfig, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig,
    upcp_pkg::ViewConfig, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig, upcp_pkg::ViewConfig,
    upcp_pkg::ViewDiag, upcp_pkg::ViewDiag
  };
  logic [2:0] kw_action [upcp_pkg::KwCount] = '{
    upcp_pkg::ActNone, upcp_pkg::ActNone, upcp_pkg::ActNone, upcp_pkg::ActNone,
    upcp_pkg::ActNone, upcp_pkg::ActNone,
    upcp_pkg::ActCaptureBaseline, upcp_pkg::ActCaptureBaseline,
    upcp_pkg::ActClearBaseline, upcp_pkg::ActClearBaseline,
    upcp_pkg::ActDefaultProfile, upcp_pkg::ActDefaultProfile,
    upcp_pkg::ActFastProfile, upcp_pkg::ActFastProfile,
    upcp_pkg::ActStableProfile, upcp_pkg::ActStableProfile,
    upcp_pkg::ActResetDiag, upcp_pkg::ActResetDiag
  };

  logic [7:0]                   slot_id;
  logic                         awaiting_slot;
  int unsigned                  cmd_len;
  logic [upcp_pkg::KwCount-1:0] kw_candidates;
  logic                         text_ended;
  logic [1:0]                   cur_view;
  logic [31:0]                  received_total;
  logic [31:0]                  fault_total;
  parse_result_t                expected_results [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [7:0] stim_slot = upcp_pkg::SlotIdReset;

  function automatic void restart_command();
    cmd_len = 0;
    kw_candidates = '1;
    text_ended = 1'b0;
  endfunction

  function automatic void keep_keywords_of_length(int unsigned n);
    for (int k = 0; k < upcp_pkg::KwCount; k++) begin
      if (kw_text[k].len() != n) begin
        kw_candidates[k] = 1'b0;
      end
    end
  endfunction

  function automatic void append_command_byte(logic [7:0] b);
    if (!text_ended) begin
      if (b == upcp_pkg::CharNul) begin
        keep_keywords_of_length(cmd_len);
        text_ended = 1'b1;
      end else begin
        for (int k = 0; k < upcp_pkg::KwCount; k++) begin
          if (cmd_len >= kw_text[k].len() || 8'(kw_text[k][cmd_len]) != b) begin
            kw_candidates[k] = 1'b0;
          end
        end
      end
    end
    cmd_len++;
  endfunction

  function automatic void parse_rx_item(logic [7:0] b, logic err);
    logic [2:0] ev;
    logic [2:0] act;
    ev = upcp_pkg::EvNone;
    act = upcp_pkg::ActNone;
    if (err) begin
      fault_total = fault_total + 1;
      ev = upcp_pkg::EvLineError;
    end else if (awaiting_slot) begin
      awaiting_slot = 1'b0;
      if (b == slot_id) begin
        received_total = received_total + 1;
        ev = upcp_pkg::EvPollResponse;
      end
    end else if (b == upcp_pkg::PollMarker) begin
      awaiting_slot = 1'b1;
    end else if (b == upcp_pkg::CharRestart) begin
      restart_command();
    end else if (b == upcp_pkg::CharCr) begin
    end else if (b == upcp_pkg::CharLf) begin
      if (cmd_len != 0) begin
        received_total = received_total + 1;
        if (!text_ended) begin
          keep_keywords_of_length(cmd_len);
        end
        ev = upcp_pkg::EvUnknown;
        for (int k = 0; k < upcp_pkg::KwCount; k++) begin
          if (kw_candidates[k] && ev == upcp_pkg::EvUnknown) begin
            ev = upcp_pkg::EvMatched;
            act = kw_action[k];
            cur_view = kw_view[k];
          end
        end
        if (ev == upcp_pkg::EvUnknown) begin
          fault_total = fault_total + 1;
        end else if (act == upcp_pkg::ActResetDiag) begin
          received_total = '0;
          fault_total = '0;
        end
        restart_command();
      end
    end else if (cmd_len < upcp_pkg::CommandCapacity - 1) begin
      append_command_byte(b);
    end else begin
      restart_command();
      fault_total = fault_total + 1;
      ev = upcp_pkg::EvOverflow;
    end
    expected_results.push_back(parse_result_t'{ev, cur_view, act, received_total,
                                               fault_total});
  endfunction

  always @(posedge clk) begin
    parse_result_t exp_r;
    parse_result_t got_r;
    if (!rst_n) begin
      slot_id = upcp_pkg::SlotIdReset;
      awaiting_slot = 1'b0;
      restart_command();
      cur_view = upcp_pkg::ViewStatus;
      received_total = '0;
      fault_total = '0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        slot_id = cfg_data;
      end
      if (in_if.valid && in_if.ready) begin
        parse_rx_item(in_if.rx_byte, in_if.line_error);
      end
      if (out_if.valid && out_if.ready) begin
        got_r = '{out_if.event_kind, out_if.view_select, out_if.sensor_action,
                  out_if.receive_count, out_if.fault_count};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("%0t: unexpected result ev=%0d view=%0d act=%0d rx=%0d flt=%0d",
                     $realtime, got_r.event_kind, got_r.view_select, got_r.sensor_action,
                     got_r.receive_count, got_r.fault_count);
          end
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.event_kind !== exp_r.event_kind ||
              got_r.view_select !== exp_r.view_select ||
              got_r.sensor_action !== exp_r.sensor_action ||
              got_r.receive_count !== exp_r.receive_count ||
              got_r.fault_count !== exp_r.fault_count) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
              $display("%0t: expected ev=%0d view=%0d act=%0d rx=%0d flt=%0d", $realtime,
                       exp_r.event_kind, exp_r.view_select, exp_r.sensor_action,
                       exp_r.receive_count, exp_r.fault_count);
              $display("%0t: actual   ev=%0d view=%0d act=%0d rx=%0d flt=%0d", $realtime,
                       got_r.event_kind, got_r.view_select, got_r.sensor_action,
                       got_r.receive_count, got_r.fault_count);
            end
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    in_if.line_error <= err;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  task automatic wait_for_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_slot_id(input logic [7:0] value);
    wait_for_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    stim_slot = value;
    @(posedge clk);
  endtask

  task automatic test_poll_handling();
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(stim_slot, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(stim_slot, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(upcp_pkg::CharLf, 1'b0);
  endtask

  task automatic test_command_parsing();
    send_byte(upcp_pkg::CharLf, 1'b0);
    send_text("c");
    send_byte(upcp_pkg::CharRestart, 1'b0);
    send_text("config");
    send_byte(upcp_pkg::CharCr, 1'b0);
    send_byte(upcp_pkg::CharNul, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(upcp_pkg::CharLf, 1'b0);
    send_text("x");
    send_byte(upcp_pkg::CharLf, 1'b0);
    send_text("sta");
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(stim_slot, 1'b0);
    send_text("tus");
    send_byte(upcp_pkg::CharLf, 1'b0);
    send_text({"reset", "_diagnostics"});
    send_byte(upcp_pkg::CharLf, 1'b0);
  endtask

  task automatic test_overflow();
    repeat (upcp_pkg::CommandCapacity - 1) send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_text("status");
    send_byte(upcp_pkg::CharLf, 1'b0);
  endtask

  task automatic test_slot_config();
    write_slot_id(8'h00);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_slot_id(8'hFF);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_slot_id(upcp_pkg::PollMarker);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(upcp_pkg::PollMarker, 1'b0);
    send_byte(8'h98, 1'b0);
  endtask

  task automatic send_random_sequence();
    int pick;
    int k;
    int n;
    string s;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 50) begin
      k = $urandom_range(upcp_pkg::KwCount - 1);
      s = kw_text[k];
      if ($urandom_range(3) == 0) begin
        send_byte(upcp_pkg::CharRestart, 1'b0);
      end
      for (int i = 0; i < s.len(); i++) begin
        b = s[i];
        if ($urandom_range(19) == 0) begin
          b = b ^ (8'h01 << $urandom_range(7));
        end
        if ($urandom_range(29) == 0) begin
          send_byte(upcp_pkg::CharCr, 1'b0);
        end
        if ($urandom_range(39) == 0) begin
          send_byte(upcp_pkg::PollMarker, 1'b0);
          send_byte(($urandom_range(1) == 0) ? stim_slot : 8'($urandom_range(255)), 1'b0);
        end
        if ($urandom_range(49) == 0) begin
          send_byte(8'($urandom_range(255)), 1'b1);
        end
        send_byte(b, 1'b0);
      end
      if ($urandom_range(9) == 0) begin
        send_byte(upcp_pkg::CharNul, 1'b0);
        n = $urandom_range(3);
        repeat (n) send_byte(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
      end
      send_byte(upcp_pkg::CharLf, 1'b0);
    end else if (pick < 65) begin
      send_byte(upcp_pkg::PollMarker, 1'b0);
      send_byte(($urandom_range(3) != 0) ? stim_slot : 8'($urandom_range(255)), 1'b0);
    end else if (pick < 73) begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end else if (pick < 85) begin
      n = $urandom_range(5, 1);
      repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 87) begin
      n = $urandom_range(70, 60);
      repeat (n) send_byte(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
      send_byte(upcp_pkg::CharLf, 1'b0);
    end else begin
      if ($urandom_range(1) == 0) begin
        s = kw_text[$urandom_range(upcp_pkg::KwCount - 1)];
        s = s.substr(0, $urandom_range(s.len() - 2));
        send_text(s);
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) send_byte(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
      end
      send_byte(upcp_pkg::CharLf, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input logic [7:0] slot);
    int start_count;
    write_slot_id(slot);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomItems / 3) begin
      send_random_sequence();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    in_if.line_error = 1'b0;
    out_if.ready = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 49;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_poll_handling();
    test_command_parsing();
    test_overflow();
    test_slot_config();
    test_random_traffic(13, 49, 8'($urandom_range(255)));
    test_random_traffic(49, 13, 8'($urandom_range(255)));
    test_random_traffic(0, 0, upcp_pkg::SlotIdReset);
    wait_for_idle();
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/upcp_pkg.sv
rtl/upcp_if.sv
rtl/uart_poll_and_command_parser_top.sv
test/tb_uart_poll_and_command_parser_top.sv
